/* rtl/htfc_pkg.sv */
package htfc_pkg;

  // Input command codes
  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_ABORT = 2'd2;

  // Frame status codes on the result channel
  localparam logic [2:0] ST_NONE  = 3'd0;
  localparam logic [2:0] ST_OK    = 3'd1;
  localparam logic [2:0] ST_CRC   = 3'd2;
  localparam logic [2:0] ST_RANGE = 3'd3;
  localparam logic [2:0] ST_ABORT = 3'd4;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_INTERVAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPIRY        = 1'b1;
  localparam logic [15:0] READ_INTERVAL_RST = 16'd2000;
  localparam logic [15:0] EXPIRY_RST        = 16'd10000;

  // Frame layout: byte position of the temperature check byte
  localparam logic [2:0] POS_T_CRC = 3'd2;

  // CRC-8 checksum
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Conversion scales; results are floor(scale * raw / 65535)
  localparam int unsigned PROD_T_W = 31;
  localparam int unsigned PROD_H_W = 30;
  localparam logic [PROD_T_W-1:0] T_SCALE = PROD_T_W'(17500);
  localparam logic [PROD_H_W-1:0] H_SCALE = PROD_H_W'(10000);
  localparam logic [14:0] T_OFFSET = 15'd4500;
  // Accepted quotient window, i.e. -4000..12500 after the offset
  localparam logic [14:0] Q_T_MIN = 15'd500;
  localparam logic [14:0] Q_T_MAX = 15'd17000;

  // Queue depth between front and back
  localparam int unsigned QDEPTH_DEF = 4;

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_NONE,
    OP_TICK,
    OP_ABORT,
    OP_CRC_ERR,
    OP_FRAME
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [PROD_T_W-1:0] prod_t;
    logic [PROD_H_W-1:0] prod_h;
  } qentry_t;

  typedef struct packed {
    logic [15:0] read_interval;
    logic [15:0] expiry;
  } cfg_t;

  // Feed one byte into the CRC-8 register, MSB first
  function automatic logic [7:0] crc8_feed(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

/* rtl/htfc_in_if.sv */
interface htfc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

/* rtl/htfc_out_if.sv */
interface htfc_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] temperature_centi;
  logic [13:0]        humidity_centi;
  logic               fresh;
  logic [2:0]         frame_status;
  logic               read_request;

  modport source (output valid, output temperature_centi, output humidity_centi,
                  output fresh, output frame_status, output read_request,
                  input ready);
  modport sink   (input valid, input temperature_centi, input humidity_centi,
                  input fresh, input frame_status, input read_request,
                  output ready);
endinterface

/* rtl/htfc_front.sv */
module htfc_front (
  input  logic              clk,
  input  logic              rst_n,
  htfc_in_if.sink           in_ch,
  output logic              push_valid,
  input  logic              push_ready,
  output htfc_pkg::qentry_t push_data
);
  import htfc_pkg::*;

  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic        first_ok_r, first_ok_nxt;
  logic [15:0] raw_t_r, raw_t_nxt;
  logic [15:0] raw_h_r, raw_h_nxt;
  logic        accept;
  logic [7:0]  crc_fed;

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;
  assign accept      = in_ch.valid & push_ready;
  assign crc_fed     = crc8_feed(crc_r, in_ch.data_byte);

  // Classify the word and advance the frame state
  always_comb begin
    pos_nxt          = pos_r;
    crc_nxt          = crc_r;
    first_ok_nxt     = first_ok_r;
    raw_t_nxt        = raw_t_r;
    raw_h_nxt        = raw_h_r;
    push_data.op     = OP_NONE;
    push_data.prod_t = PROD_T_W'(raw_t_r) * T_SCALE;
    push_data.prod_h = PROD_H_W'(raw_h_r) * H_SCALE;
    case (in_ch.cmd)
      CMD_BYTE: begin
        case (pos_r)
          3'd0, 3'd1: begin
            crc_nxt   = crc_fed;
            raw_t_nxt = {raw_t_r[7:0], in_ch.data_byte};
            pos_nxt   = pos_r + 3'd1;
          end
          POS_T_CRC: begin
            first_ok_nxt = (crc_r == in_ch.data_byte);
            crc_nxt      = CRC_INIT;
            pos_nxt      = pos_r + 3'd1;
          end
          3'd3, 3'd4: begin
            crc_nxt   = crc_fed;
            raw_h_nxt = {raw_h_r[7:0], in_ch.data_byte};
            pos_nxt   = pos_r + 3'd1;
          end
          default: begin
            push_data.op = (!first_ok_r || crc_r != in_ch.data_byte) ? OP_CRC_ERR
                                                                      : OP_FRAME;
            pos_nxt      = 3'd0;
            crc_nxt      = CRC_INIT;
            first_ok_nxt = 1'b0;
          end
        endcase
      end
      CMD_TICK: begin
        push_data.op = OP_TICK;
      end
      CMD_ABORT: begin
        push_data.op = (pos_r != 3'd0) ? OP_ABORT : OP_NONE;
        pos_nxt      = 3'd0;
        crc_nxt      = CRC_INIT;
        first_ok_nxt = 1'b0;
      end
      default: begin
        push_data.op = OP_NONE;
      end
    endcase
  end

  // Hold frame state until a word is accepted
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= 3'd0;
      crc_r      <= CRC_INIT;
      first_ok_r <= 1'b0;
      raw_t_r    <= 16'd0;
      raw_h_r    <= 16'd0;
    end else if (accept) begin
      pos_r      <= pos_nxt;
      crc_r      <= crc_nxt;
      first_ok_r <= first_ok_nxt;
      raw_t_r    <= raw_t_nxt;
      raw_h_r    <= raw_h_nxt;
    end
  end

endmodule

/* rtl/htfc_queue.sv */
module htfc_queue #(
  parameter int unsigned DEPTH = htfc_pkg::QDEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  htfc_pkg::qentry_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output htfc_pkg::qentry_t pop_data
);
  import htfc_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  qentry_t           slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_r, wr_nxt;
  logic [PTR_W-1:0]  rd_r, rd_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = slot_r[rd_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  // Advance pointers with wrap and track fill level
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= push_data;
    end
  end

endmodule

/* rtl/htfc_back.sv */
module htfc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  htfc_pkg::cfg_t    cfg,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  htfc_pkg::qentry_t pop_data,
  htfc_out_if.source        out_ch
);
  import htfc_pkg::*;

  logic signed [14:0] temp_r, temp_nxt;
  logic [13:0]        hum_r, hum_nxt;
  logic               valid_r, valid_nxt;
  logic [15:0]        since_ok_r, since_ok_nxt;
  logic [15:0]        since_req_r, since_req_nxt;
  logic               req;
  logic [2:0]         status;
  logic               do_pop;

  logic               out_valid_r;
  logic signed [14:0] out_temp_r;
  logic [13:0]        out_hum_r;
  logic               out_fresh_r;
  logic [2:0]         out_status_r;
  logic               out_req_r;

  logic [31:0]        sum_t, sum_h;
  logic [14:0]        q_t;
  logic [13:0]        q_h;
  logic [15:0]        ok_inc, req_inc;

  assign pop_ready = !out_valid_r || out_ch.ready;
  assign do_pop    = pop_valid & pop_ready;

  // Divide the products by 65535: q = (x + (x >> 16) + 1) >> 16
  assign sum_t = 32'(pop_data.prod_t) + 32'(pop_data.prod_t >> 16) + 32'd1;
  assign sum_h = 32'(pop_data.prod_h) + 32'(pop_data.prod_h >> 16) + 32'd1;
  assign q_t   = sum_t[30:16];
  assign q_h   = sum_h[29:16];

  assign ok_inc  = (since_ok_r == 16'hFFFF) ? since_ok_r : since_ok_r + 16'd1;
  assign req_inc = (since_req_r == 16'hFFFF) ? since_req_r : since_req_r + 16'd1;

  // Carry out the operation
  always_comb begin
    temp_nxt      = temp_r;
    hum_nxt       = hum_r;
    valid_nxt     = valid_r;
    since_ok_nxt  = since_ok_r;
    since_req_nxt = since_req_r;
    req           = 1'b0;
    status        = ST_NONE;
    case (pop_data.op)
      OP_TICK: begin
        since_ok_nxt  = ok_inc;
        since_req_nxt = req_inc;
        if (req_inc >= cfg.read_interval) begin
          req           = 1'b1;
          since_req_nxt = 16'd0;
        end
      end
      OP_ABORT: begin
        status = ST_ABORT;
      end
      OP_CRC_ERR: begin
        status = ST_CRC;
      end
      OP_FRAME: begin
        if (q_t < Q_T_MIN || q_t > Q_T_MAX) begin
          status = ST_RANGE;
        end else begin
          temp_nxt     = $signed(q_t - T_OFFSET);
          hum_nxt      = q_h;
          valid_nxt    = 1'b1;
          since_ok_nxt = 16'd0;
          status       = ST_OK;
        end
      end
      default: begin
        status = ST_NONE;
      end
    endcase
  end

  // Update reading state and load the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_r      <= '0;
      hum_r       <= '0;
      valid_r     <= 1'b0;
      since_ok_r  <= 16'd0;
      since_req_r <= 16'hFFFF;
      out_valid_r <= 1'b0;
    end else begin
      if (do_pop) begin
        temp_r      <= temp_nxt;
        hum_r       <= hum_nxt;
        valid_r     <= valid_nxt;
        since_ok_r  <= since_ok_nxt;
        since_req_r <= since_req_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Latch the result word payload
  always_ff @(posedge clk) begin
    if (do_pop) begin
      out_temp_r   <= temp_nxt;
      out_hum_r    <= hum_nxt;
      out_fresh_r  <= valid_nxt && (since_ok_nxt <= cfg.expiry);
      out_status_r <= status;
      out_req_r    <= req;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.temperature_centi = out_temp_r;
  assign out_ch.humidity_centi    = out_hum_r;
  assign out_ch.fresh             = out_fresh_r;
  assign out_ch.frame_status      = out_status_r;
  assign out_ch.read_request      = out_req_r;

endmodule

/* rtl/humidity_temp_frame_checker.sv */
// Humidity/temperature frame checker. Each input word is a sensor response
// byte, a millisecond tick or a frame abort; every accepted word yields exactly
// one result word carrying the stored reading, its freshness, the frame status
// and the periodic read request. The block takes one word per clock cycle while
// the queue has room; a result passes a queue slot, then the output register.
// The front decodes the six-byte frame and checks both CRC-8 bytes, forming the
// two scale products at the sixth byte; a queue of QDEPTH words lets the input
// keep flowing for QDEPTH words plus the output register while the result side
// stalls; the back divides by 65535, range-checks the temperature and keeps the
// age and request counters. Configuration is written through cfg_we, cfg_index
// and cfg_wdata and should only change while no word is in flight.
module humidity_temp_frame_checker #(
  parameter int unsigned QDEPTH = htfc_pkg::QDEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  htfc_in_if.sink                          in_ch,
  htfc_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [htfc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [htfc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import htfc_pkg::*;

  cfg_t    cfg_r;
  logic    push_valid, push_ready;
  qentry_t push_data;
  logic    pop_valid, pop_ready;
  qentry_t pop_data;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.read_interval <= READ_INTERVAL_RST;
      cfg_r.expiry        <= EXPIRY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_READ_INTERVAL: cfg_r.read_interval <= cfg_wdata;
        CFG_EXPIRY:        cfg_r.expiry        <= cfg_wdata;
        default:           cfg_r               <= cfg_r;
      endcase
    end
  end

  htfc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  htfc_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  htfc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule
